// ===== rtl/core/rsi_pkg.sv =====
package rsi_pkg;

  localparam int NUM_REGS_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 40;

  localparam int REG_IDX_W = 8;
  localparam int LAT_W     = 4;
  localparam int ISSUE_W   = 4;
  localparam int OUT_W     = 40;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LOAD_LATENCY = 1'b0;
  localparam logic [LAT_W-1:0]     LOAD_LAT_RESET   = 4'd1;
  localparam logic [ISSUE_W-1:0]   ISSUE_MAX        = 4'd15;

  typedef struct packed {
    logic                 src1_valid;
    logic [REG_IDX_W-1:0] src1_reg;
    logic                 src2_valid;
    logic [REG_IDX_W-1:0] src2_reg;
    logic                 dst_valid;
    logic [REG_IDX_W-1:0] dst_reg;
    logic                 is_load;
    logic                 first_micro_op;
  } op_t;

  typedef struct packed {
    logic [ISSUE_W-1:0] issue_cycles;
    logic [OUT_W-1:0]   total_cycles;
    logic [OUT_W-1:0]   micro_op_count;
    logic [OUT_W-1:0]   macro_op_count;
  } result_t;

endpackage

// ===== rtl/core/rsi_ram.sv =====
module rsi_ram #(
  parameter int WIDTH    = 40,
  parameter int DEPTH    = 256,
  parameter int NUM_READ = 2,
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [NUM_READ-1:0][AW-1:0]      raddr,
  output logic [NUM_READ-1:0][WIDTH-1:0]   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  for (genvar i = 0; i < NUM_READ; i++) begin : g_rd
    always_ff @(posedge clk) begin
      rdata[i] <= mem[raddr[i]];
    end
  end

endmodule

// ===== rtl/core/rsi_apb.sv =====
module rsi_apb (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rsi_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rsi_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rsi_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [rsi_pkg::LAT_W-1:0]        load_latency
);

  logic [rsi_pkg::CFG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[rsi_pkg::APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_latency <= rsi_pkg::LOAD_LAT_RESET;
    end else if (wr_en && reg_idx == rsi_pkg::REG_LOAD_LATENCY) begin
      load_latency <= pwdata[rsi_pkg::LAT_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      rsi_pkg::REG_LOAD_LATENCY: prdata = rsi_pkg::APB_DATA_W'(load_latency);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/register_scoreboard_issue_core.sv =====
// result: done is registered after the s1_valid and s2_valid stages, one cycle wide
// issue: busy refuses a new item while the last sits in stage one, for the table read then write-back
// and for the cycle count that the next item starts from
// reset: a clearing pass writes zero to all NUM_REGS table entries, one a cycle,
// with busy high throughout; load latency returns to 1
// here the receiver cannot stall
module register_scoreboard_issue_core #(
  parameter int NUM_REGS    = rsi_pkg::NUM_REGS_DEF,
  parameter int COUNT_WIDTH = rsi_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  rsi_pkg::op_t                   op,
  output logic                           done,
  output rsi_pkg::result_t               result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rsi_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rsi_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rsi_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CW = COUNT_WIDTH;

  logic [rsi_pkg::LAT_W-1:0] load_latency;

  logic          clr_active;
  logic [AW-1:0] clr_idx;

  logic s1_valid, s2_valid, accept;

  logic          s1_src1_en, s1_src2_en, s1_dst_en;
  logic          s1_fwd1, s1_fwd2, s1_fwdd;
  logic [CW-1:0] s1_fwd_val;
  logic [AW-1:0] s1_dst_addr;
  logic          s1_load, s1_first;

  logic [CW-1:0] s2_t;
  logic          s2_dst_en;
  logic [AW-1:0] s2_dst_addr;
  logic          s2_load, s2_first;

  logic [CW-1:0] cycle_now, micro_total, macro_total;

  logic          in_src1, in_src2, in_dst;
  logic [AW-1:0] a_src1, a_src2, a_dst;

  logic          we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic [1:0][AW-1:0] src_raddr;
  logic [1:0][CW-1:0] src_rdata;
  logic [0:0][AW-1:0] dst_raddr;
  logic [0:0][CW-1:0] dst_rdata;

  logic [CW-1:0] r1, r2, rd, m_src, m_dst, t_next;

  logic          s2_wr;
  logic [CW-1:0] lat_add, ready_new, cycle_next, micro_next, macro_next, diff;
  logic [CW:0]   sum_lat, sum_cyc, sum_micro, sum_macro;
  logic [rsi_pkg::ISSUE_W-1:0] spent;

  rsi_apb u_apb (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .load_latency (load_latency)
  );

  assign busy   = clr_active | s1_valid;
  assign accept = start & ~busy;

  assign in_src1 = 32'(op.src1_reg) < NUM_REGS;
  assign in_src2 = 32'(op.src2_reg) < NUM_REGS;
  assign in_dst  = 32'(op.dst_reg) < NUM_REGS;
  assign a_src1  = AW'(op.src1_reg);
  assign a_src2  = AW'(op.src2_reg);
  assign a_dst   = AW'(op.dst_reg);

  assign src_raddr[0] = a_src1;
  assign src_raddr[1] = a_src2;
  assign dst_raddr[0] = a_dst;

  // stage two write-back, or the clearing pass
  assign s2_wr = s2_valid & s2_dst_en;
  assign we    = clr_active | s2_wr;
  assign waddr = clr_active ? clr_idx : s2_dst_addr;
  assign wdata = clr_active ? '0 : ready_new;

  rsi_ram #(.WIDTH(CW), .DEPTH(NUM_REGS), .NUM_READ(2)) u_src_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  rsi_ram #(.WIDTH(CW), .DEPTH(NUM_REGS), .NUM_READ(1)) u_dst_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (dst_raddr),
    .rdata (dst_rdata)
  );

  // stage one: issue cycle is the latest of now and the three ready times
  assign r1 = !s1_src1_en ? '0 : (s1_fwd1 ? s1_fwd_val : src_rdata[0]);
  assign r2 = !s1_src2_en ? '0 : (s1_fwd2 ? s1_fwd_val : src_rdata[1]);
  assign rd = !s1_dst_en  ? '0 : (s1_fwdd ? s1_fwd_val : dst_rdata[0]);

  assign m_src  = (r1 > r2) ? r1 : r2;
  assign m_dst  = (rd > cycle_now) ? rd : cycle_now;
  assign t_next = (m_src > m_dst) ? m_src : m_dst;

  // stage two: saturating updates
  assign lat_add   = s2_load ? CW'(load_latency) : CW'(1);
  assign sum_lat   = {1'b0, s2_t} + {1'b0, lat_add};
  assign ready_new = sum_lat[CW] ? '1 : sum_lat[CW-1:0];
  assign sum_cyc   = {1'b0, s2_t} + (CW+1)'(1);
  assign cycle_next = sum_cyc[CW] ? '1 : sum_cyc[CW-1:0];
  assign sum_micro = {1'b0, micro_total} + (CW+1)'(1);
  assign micro_next = sum_micro[CW] ? '1 : sum_micro[CW-1:0];
  assign sum_macro = {1'b0, macro_total} + (CW+1)'(1);
  assign macro_next = !s2_first ? macro_total : (sum_macro[CW] ? '1 : sum_macro[CW-1:0]);
  assign diff      = s2_t - cycle_now;
  assign spent     = (diff >= CW'(rsi_pkg::ISSUE_MAX)) ? rsi_pkg::ISSUE_MAX
                                                        : rsi_pkg::ISSUE_W'(diff) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active  <= 1'b1;
      clr_idx     <= '0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      done        <= 1'b0;
      cycle_now   <= '0;
      micro_total <= '0;
      macro_total <= '0;
    end else begin
      if (clr_active) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == AW'(NUM_REGS - 1)) begin
          clr_active <= 1'b0;
        end
      end
      s1_valid <= accept;
      s2_valid <= s1_valid;
      done     <= s2_valid;
      if (s2_valid) begin
        cycle_now   <= cycle_next;
        micro_total <= micro_next;
        macro_total <= macro_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src1_en  <= op.src1_valid & in_src1;
      s1_src2_en  <= op.src2_valid & in_src2;
      s1_dst_en   <= op.dst_valid & in_dst;
      s1_dst_addr <= a_dst;
      s1_load     <= op.is_load;
      s1_first    <= op.first_micro_op;
      s1_fwd1     <= s2_wr && s2_dst_addr == a_src1;
      s1_fwd2     <= s2_wr && s2_dst_addr == a_src2;
      s1_fwdd     <= s2_wr && s2_dst_addr == a_dst;
      s1_fwd_val  <= ready_new;
    end
    if (s1_valid) begin
      s2_t        <= t_next;
      s2_dst_en   <= s1_dst_en;
      s2_dst_addr <= s1_dst_addr;
      s2_load     <= s1_load;
      s2_first    <= s1_first;
    end
    if (s2_valid) begin
      result.issue_cycles   <= spent;
      result.total_cycles   <= rsi_pkg::OUT_W'(cycle_next);
      result.micro_op_count <= rsi_pkg::OUT_W'(micro_next);
      result.macro_op_count <= rsi_pkg::OUT_W'(macro_next);
    end
  end

  a_stage_done: assert property (@(posedge clk) disable iff (rst)
    s2_valid |=> done)
    else $error("result strobe missing after write-back stage");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> busy && !s1_valid && !s2_valid)
    else $error("item in flight during clearing pass");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !s2_valid)
    else $error("two items in flight");

  a_cycle_grows: assert property (@(posedge clk) disable iff (rst)
    s2_valid |=> (cycle_now > $past(cycle_now)) || (cycle_now == '1))
    else $error("cycle count failed to advance");

endmodule

// ===== sim/issue_checker.sv =====
module issue_checker
  import rsi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  op_t                   op,
  input  logic                  done,
  input  result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int unsigned           failures,
  output int unsigned           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [OUT_W-1:0] count_t;

  count_t           ready_at [NUM_REGS_DEF];
  count_t           cycle_now;
  count_t           uop_total;
  count_t           mop_total;
  logic [LAT_W-1:0] load_lat;
  result_t          expected_results [$];
  result_t          want;

  initial begin
    failures = 0;
    pending  = 0;
  end

  function automatic count_t sat_add(count_t a, count_t b);
    logic [OUT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[OUT_W] ? '1 : sum[OUT_W-1:0];
  endfunction

  // works out when the op issues and updates the table and running totals
  function automatic result_t predict_issue(op_t o);
    result_t r;
    count_t  t;
    count_t  begin_at;
    count_t  stalled;
    begin_at = cycle_now;
    t = begin_at;
    if (o.src1_valid && ready_at[o.src1_reg] > t) t = ready_at[o.src1_reg];
    if (o.src2_valid && ready_at[o.src2_reg] > t) t = ready_at[o.src2_reg];
    if (o.dst_valid && ready_at[o.dst_reg] > t) t = ready_at[o.dst_reg];
    if (o.dst_valid) begin
      ready_at[o.dst_reg] = sat_add(t, o.is_load ? count_t'(load_lat) : count_t'(1));
    end
    cycle_now = sat_add(t, 1);
    uop_total = sat_add(uop_total, 1);
    if (o.first_micro_op) mop_total = sat_add(mop_total, 1);
    stalled = t - begin_at;
    r.issue_cycles   = (stalled >= count_t'(ISSUE_MAX)) ? ISSUE_MAX
                                                        : stalled[ISSUE_W-1:0] + 1'b1;
    r.total_cycles   = cycle_now;
    r.micro_op_count = uop_total;
    r.macro_op_count = mop_total;
    return r;
  endfunction

  task automatic check_field(string name, count_t exp_v, count_t got_v);
    if (exp_v !== got_v) begin
      failures++;
      if (failures <= 10) begin
        $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, got_v);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (ready_at[i]) ready_at[i] = '0;
      cycle_now = '0;
      uop_total = '0;
      mop_total = '0;
      load_lat  = LOAD_LAT_RESET;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= 10) $display("%0t: result with no item outstanding", $time);
        end else begin
          want = expected_results.pop_front();
          check_field("issue_cycles", count_t'(want.issue_cycles),
                      count_t'(result.issue_cycles));
          check_field("total_cycles", want.total_cycles, result.total_cycles);
          check_field("micro_op_count", want.micro_op_count, result.micro_op_count);
          check_field("macro_op_count", want.macro_op_count, result.macro_op_count);
        end
      end
      if (start && !busy) expected_results.push_back(predict_issue(op));
      if (psel && penable && pwrite && pready && (paddr >> 2) == REG_LOAD_LATENCY) begin
        load_lat = pwdata[LAT_W-1:0];
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== sim/tb_register_scoreboard_issue_core.sv =====
module tb_register_scoreboard_issue_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rsi_pkg::*;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  start   = 1'b0;
  op_t                   op      = '0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic                  busy;
  logic                  done;
  result_t               result;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int unsigned           failures;
  int unsigned           pending;

  register_scoreboard_issue_core dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .op      (op),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  issue_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .done     (done),
    .result   (result),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .failures (failures),
    .pending  (pending)
  );

  always #6 clk = ~clk;

  function automatic op_t mk(logic s1v, logic [7:0] s1, logic s2v, logic [7:0] s2,
                             logic dv, logic [7:0] d, logic ld, logic first);
    op_t o;
    o.src1_valid     = s1v;
    o.src1_reg       = s1;
    o.src2_valid     = s2v;
    o.src2_reg       = s2;
    o.dst_valid      = dv;
    o.dst_reg        = d;
    o.is_load        = ld;
    o.first_micro_op = first;
    return o;
  endfunction

  // mostly a small register pool so that ops depend on each other
  function automatic op_t rand_op();
    logic [31:0] rnd;
    op_t         o;
    rnd = $urandom;
    o = rnd[$bits(op_t)-1:0];
    if ($urandom_range(0, 3) != 0) begin
      o.src1_reg = REG_IDX_W'($urandom_range(0, 7));
      o.src2_reg = REG_IDX_W'($urandom_range(0, 7));
      o.dst_reg  = REG_IDX_W'($urandom_range(0, 7));
    end
    return o;
  endfunction

  task automatic drive_op(op_t o);
    start <= 1'b1;
    op    <= o;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic set_latency(logic [LAT_W-1:0] lat);
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(REG_LOAD_LATENCY) << 2;
    pwdata  <= APB_DATA_W'(lat);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int burst;
    int gap;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      drive_op(rand_op());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    int guard;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);
    while (busy) @(negedge clk);

    // load latency at its reset value
    drive_op(mk(0, 8'h00, 0, 8'h00, 0, 8'h00, 0, 1));
    drive_op(mk(1, 8'hFF, 1, 8'hFF, 1, 8'hFF, 1, 1));
    drive_op(mk(1, 8'hFF, 0, 8'h00, 1, 8'h00, 0, 0));
    drive_op(mk(0, 8'h00, 1, 8'h00, 1, 8'h00, 1, 0));
    start <= 1'b0;

    // longest load latency: read after load, write after write, unused fields
    set_latency(4'd15);
    drive_op(mk(0, 8'h00, 0, 8'h00, 1, 8'h05, 1, 1));
    drive_op(mk(1, 8'h05, 0, 8'h00, 1, 8'h06, 0, 0));
    drive_op(mk(0, 8'h00, 0, 8'h00, 1, 8'h07, 1, 1));
    drive_op(mk(0, 8'h00, 1, 8'h07, 0, 8'h00, 0, 0));
    drive_op(mk(0, 8'h00, 0, 8'h00, 1, 8'h09, 1, 1));
    drive_op(mk(0, 8'h09, 0, 8'h09, 0, 8'h09, 0, 0));
    drive_op(mk(0, 8'h00, 0, 8'h00, 1, 8'h09, 0, 1));
    drive_op(mk(1, 8'hAA, 1, 8'h55, 1, 8'hAA, 1, 0));
    drive_op(mk(1, 8'h55, 1, 8'hAA, 0, 8'h00, 0, 1));
    start <= 1'b0;

    // zero latency: a load result is ready at once
    set_latency(4'd0);
    drive_op(mk(0, 8'h00, 0, 8'h00, 1, 8'h03, 1, 1));
    drive_op(mk(1, 8'h03, 1, 8'h03, 1, 8'h03, 1, 0));
    drive_op(mk(1, 8'hFF, 1, 8'hFF, 1, 8'hFF, 0, 1));
    start <= 1'b0;

    set_latency(4'd1);
    random_phase(175);
    set_latency(4'd15);
    random_phase(175);
    set_latency(4'd0);
    random_phase(175);
    set_latency(4'd7);
    random_phase(175);
    set_latency(4'($urandom_range(0, 15)));
    random_phase(175);
    set_latency(4'($urandom_range(2, 14)));
    random_phase(175);

    guard = 0;
    while (pending != 0 && guard < 500) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rsi_pkg.sv
rtl/core/rsi_ram.sv
rtl/core/rsi_apb.sv
rtl/core/register_scoreboard_issue_core.sv
sim/issue_checker.sv
sim/tb_register_scoreboard_issue_core.sv
